@@ rtl/erc_pkg.sv @@
`timescale 1ns / 1ps

package erc_pkg;

    // item kinds carried in the low bits of s_tuser
    typedef enum logic [2:0] {
        FN_EDGE        = 3'd0,
        FN_WINDOW      = 3'd1,
        FN_READ_COUNT  = 3'd2,
        FN_READ_SCALED = 3'd3,
        FN_READ_PERIOD = 3'd4,
        FN_RESTART     = 3'd5,
        FN_CLEAR_FILT  = 3'd6
    } func_t;

    // right shift applied to the product before it enters the divider
    typedef enum logic [1:0] {
        SHR_0  = 2'd0,
        SHR_8  = 2'd1,
        SHR_16 = 2'd2
    } shr_t;

    localparam int OPA_W      = 32;
    localparam int OPB_W      = 16;
    localparam int NUM_W      = OPA_W + OPB_W;
    localparam int DIV_W      = 16;
    localparam int RADIX_BITS = 2;
    localparam int DIV_CYCLES = NUM_W / RADIX_BITS;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    // register map
    localparam int          ADDR_W       = 4;
    localparam logic [3:0]  ADDR_WINDOW  = 4'h0;
    localparam logic [3:0]  ADDR_SPEED   = 4'h4;
    localparam logic [3:0]  ADDR_CAPTURE = 4'h8;

    localparam logic [15:0] WINDOW_RST = 16'd1000;
    localparam logic [15:0] SPEED_RST  = 16'd256;

    typedef struct packed {
        logic             start;
        logic [OPA_W-1:0] op_a;
        logic [OPB_W-1:0] op_b;
        shr_t             shr;
    } md_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } md_rsp_t;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

@@ rtl/erc_muldiv.sv @@
`timescale 1ns / 1ps

module erc_muldiv (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  erc_pkg::md_req_t        req,
    input  logic [15:0]             divisor,
    output erc_pkg::md_rsp_t        rsp
);
    import erc_pkg::*;

    logic [NUM_W-1:0] prod;
    logic [NUM_W-1:0] prod_shr;
    logic [DIV_W-1:0] dvs;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] r_work;
    logic [NUM_W-1:0] n_work;

    // zero window divides as one
    assign dvs  = (divisor == '0) ? DIV_W'(1) : divisor;
    assign prod = req.op_a * req.op_b;

    always_comb begin
        case (req.shr)
            SHR_0:   prod_shr = prod;
            SHR_8:   prod_shr = prod >> 8;
            SHR_16:  prod_shr = prod >> 16;
            default: prod_shr = prod;
        endcase
    end

    // two restoring division steps per cycle, quotient shifts into num
    always_comb begin
        r_work = rem_reg;
        n_work = num_reg;
        trial  = '0;
        for (int i = 0; i < RADIX_BITS; i++) begin
            trial  = {r_work, n_work[NUM_W-1]};
            n_work = {n_work[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs}) begin
                trial     = trial - {1'b0, dvs};
                n_work[0] = 1'b1;
            end
            r_work = trial[DIV_W-1:0];
        end
        rem_next = r_work;
        num_next = n_work;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // pulse after the last divide step
            done_reg <= run_reg && !req.start && (cnt_reg == CNT_W'(DIV_CYCLES - 1));
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= prod_shr;
            rem_reg <= '0;
        end else if (run_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

@@ rtl/edge_rate_counter_with_filter_core.sv @@
`timescale 1ns / 1ps

// channel   | ports        | contents
// ----------+--------------+-------------------------------------------------
// input     | s_t*         | tdata: timestamp_us, scale; tuser: func, use_filtered
// result    | m_t*         | tdata: value, period_us; tuser: new_data
// config    | APB p*       | 0x0 window_ms, 0x4 filter_speed, 0x8 time_capture_on
//
// edge, read count, read period, restart, clear filter and unused codes pass
// through the exec and write states; window end and read scaled also pass
// through wait and fix, for the shared multiply / 2-bit-per-cycle divide unit
// one item is in flight at a time; s_tready is low until its result is loaded
// into the output register, which a stalled m_tready holds
// reset is synchronous and active low

module edge_rate_counter_with_filter_core #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // timestamp_us[31:0], scale[47:32]
    input  logic [3:0]                 s_tuser,   // func[2:0], use_filtered[3]
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,   // value[15:0], period_us[47:16]
    output logic                       m_tuser,   // new_data[0]
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [erc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import erc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_FIX   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    // configuration registers
    logic [15:0] window_reg;
    logic [15:0] speed_reg;
    logic        capture_reg;
    logic        cfg_wr;

    // counter and filter state
    logic [COUNT_BITS-1:0] edge_count_reg;
    logic [COUNT_BITS-1:0] latched_reg;
    logic [31:0]           filt_reg;
    logic                  count_rdy_reg;
    logic [TIME_BITS-1:0]  cur_time_reg;
    logic [TIME_BITS-1:0]  prev_time_reg;
    logic                  period_rdy_reg;

    // sequencer and the item being worked on
    state_t               state_reg;
    func_t                func_reg;
    logic [TIME_BITS-1:0] ts_reg;
    logic                 use_f_reg;
    logic [15:0]          scale_reg;
    logic                 up_reg;
    logic [15:0]          val_reg;
    logic                 flag_reg;

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        out_load;

    logic        s_xfer;
    logic [15:0] lat_sat;
    logic [15:0] edge_sat;
    logic [31:0] target;
    logic        up_dir;
    logic [31:0] mag;
    logic [48:0] sum_up;
    logic [31:0] filt_up;
    logic [31:0] filt_dn;
    logic [15:0] quot_sat;
    logic [TIME_BITS-1:0] period_diff;

    md_req_t req;
    md_rsp_t rsp;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RST;
            speed_reg   <= SPEED_RST;
            capture_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_WINDOW:  window_reg  <= pwdata[15:0];
                ADDR_SPEED:   speed_reg   <= pwdata[15:0];
                ADDR_CAPTURE: capture_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_WINDOW:  prdata = {16'h0, window_reg};
            ADDR_SPEED:   prdata = {16'h0, speed_reg};
            ADDR_CAPTURE: prdata = {31'h0, capture_reg};
            default:      prdata = 32'h0;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // result moves into the output register when it is free or draining
    assign out_load = (state_reg == ST_WRITE) && (!m_tvalid_reg || m_tready);

    assign lat_sat  = sat16(32'(latched_reg));
    assign edge_sat = sat16(32'(edge_count_reg));

    // filter target is the newly latched count in Q16.16
    assign target = {edge_sat, 16'h0};
    assign up_dir = (target >= filt_reg);
    assign mag    = up_dir ? (target - filt_reg) : (filt_reg - target);

    // shared unit request: speed*|diff|/256 or count*scale, then / window
    always_comb begin
        req.start = (state_reg == ST_EXEC) &&
                    ((func_reg == FN_WINDOW) || (func_reg == FN_READ_SCALED));
        if (func_reg == FN_WINDOW) begin
            req.op_a = mag;
            req.op_b = speed_reg;
            req.shr  = SHR_8;
        end else if (use_f_reg) begin
            req.op_a = filt_reg;
            req.op_b = scale_reg;
            req.shr  = SHR_16;
        end else begin
            req.op_a = 32'(latched_reg);
            req.op_b = scale_reg;
            req.shr  = SHR_0;
        end
    end

    erc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .divisor (window_reg),
        .rsp     (rsp)
    );

    // filter step applied with clamping
    assign sum_up   = {17'h0, filt_reg} + {1'b0, rsp.quot};
    assign filt_up  = (|sum_up[48:32]) ? 32'hFFFF_FFFF : sum_up[31:0];
    assign filt_dn  = (rsp.quot >= {16'h0, filt_reg}) ? 32'h0 : (filt_reg - rsp.quot[31:0]);
    assign quot_sat = (|rsp.quot[NUM_W-1:16]) ? 16'hFFFF : rsp.quot[15:0];

    assign period_diff = cur_time_reg - prev_time_reg;

    // ---------------------------------------------------------------
    // sequencer and state updates
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edge_count_reg <= '0;
            latched_reg    <= '0;
            filt_reg       <= '0;
            count_rdy_reg  <= 1'b0;
            cur_time_reg   <= '0;
            prev_time_reg  <= '0;
            period_rdy_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    // items that start the shared unit wait for it
                    state_reg <= req.start ? ST_WAIT : ST_WRITE;
                    case (func_reg)
                        FN_EDGE: begin
                            if (edge_count_reg != '1) begin
                                edge_count_reg <= edge_count_reg + COUNT_BITS'(1);
                            end
                            if (capture_reg) begin
                                prev_time_reg  <= cur_time_reg;
                                cur_time_reg   <= ts_reg;
                                period_rdy_reg <= 1'b1;
                            end
                        end
                        FN_WINDOW: begin
                            latched_reg    <= edge_count_reg;
                            edge_count_reg <= '0;
                            count_rdy_reg  <= 1'b1;
                        end
                        FN_READ_COUNT: begin
                            count_rdy_reg <= 1'b0;
                        end
                        FN_READ_PERIOD: begin
                            period_rdy_reg <= 1'b0;
                        end
                        FN_RESTART: begin
                            cur_time_reg   <= ts_reg;
                            prev_time_reg  <= ts_reg;
                            period_rdy_reg <= 1'b0;
                        end
                        FN_CLEAR_FILT: begin
                            filt_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_WAIT: begin
                    if (rsp.done) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    state_reg <= ST_WRITE;
                    if (func_reg == FN_WINDOW) begin
                        filt_reg <= up_reg ? filt_up : filt_dn;
                    end else begin
                        count_rdy_reg <= 1'b0;
                    end
                end
                ST_WRITE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item capture, pending result and output payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            func_reg  <= func_t'(s_tuser[2:0]);
            use_f_reg <= s_tuser[3];
            ts_reg    <= TIME_BITS'(s_tdata[31:0]);
            scale_reg <= s_tdata[47:32];
        end
        if (state_reg == ST_EXEC) begin
            up_reg <= up_dir;
            case (func_reg)
                FN_WINDOW: begin
                    val_reg  <= edge_sat;
                    flag_reg <= 1'b0;
                end
                FN_READ_COUNT: begin
                    val_reg  <= use_f_reg ? filt_reg[31:16] : lat_sat;
                    flag_reg <= count_rdy_reg;
                end
                FN_READ_PERIOD: begin
                    val_reg  <= lat_sat;
                    flag_reg <= period_rdy_reg;
                end
                default: begin
                    val_reg  <= lat_sat;
                    flag_reg <= 1'b0;
                end
            endcase
        end
        if ((state_reg == ST_FIX) && (func_reg == FN_READ_SCALED)) begin
            val_reg  <= quot_sat;
            flag_reg <= count_rdy_reg;
        end
        if (out_load) begin
            m_tdata_reg <= {32'(period_diff), val_reg};
            m_tuser_reg <= flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // one item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // the divider only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

    // a clear-filter item leaves the filter at zero
    a_clear_filt: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && (func_reg == FN_CLEAR_FILT)) |=> (filt_reg == 32'h0))
        else $error("filter not cleared");

endmodule
